FILE: design/wrsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsg_pkg: shared types and constants of the wrap run segmenter
// Character classes, controller states, command/status bundles, result word
// layout and the saturating adder.
// ----------------------------------------------------------------------------
package wrsg_pkg;

	localparam int CP_W   = 21;
	localparam int BC_W   = 3;
	localparam int GW_W   = 2;
	localparam int TS_W   = 7;
	localparam int SEG_W  = 16;
	localparam int FLAG_W = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 88;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [SEG_W-1:0] MAX_LINE_BYTES = 16'hFFFF;
	localparam logic [SEG_W-1:0] WIDTH_MAX      = 16'hFFFF;
	localparam logic [TS_W-1:0]  TAB_STOP_RST   = 7'd8;

	localparam logic [CP_W-1:0] CP_TAB   = 21'd9;
	localparam logic [CP_W-1:0] CP_SPACE = 21'd32;
	localparam logic [CP_W-1:0] CP_DEL   = 21'd127;

	localparam logic [FLAG_W-1:0] FLAG_TAB  = 3'b001;
	localparam logic [FLAG_W-1:0] FLAG_CTRL = 3'b010;
	localparam logic [FLAG_W-1:0] FLAG_WIDE = 3'b100;

	localparam logic REG_TAB_STOP = 1'b0;

	localparam logic [3:0] DIV_FIRST_BIT = 4'd15;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_SPACE = 2'd1,
		KIND_TAB   = 2'd2,
		KIND_CTRL  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic commit_live;
		logic start_div;
		logic div_step;
		logic commit_held;
	} cmd_t;

	typedef struct packed {
		logic room;
		logic live_tab;
		logic div_last;
	} status_t;

	typedef struct packed {
		logic [SEG_W-1:0]  offset;
		logic [SEG_W-1:0]  bytes;
		logic [SEG_W-1:0]  width;
		logic [SEG_W-1:0]  chars;
		kind_t             kind;
		logic [FLAG_W-1:0] flags;
		logic [SEG_W-1:0]  total;
		logic              final_seg;
	} seg_t;

	function automatic logic [SEG_W-1:0] sat_add(input logic [SEG_W-1:0] a,
			input logic [SEG_W-1:0] b, input logic [SEG_W-1:0] lim);
		logic [SEG_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s > {1'b0, lim}) ? lim : s[SEG_W-1:0];
	endfunction

endpackage

FILE: design/wrap_run_segmenter_core.sv
`timescale 1ns / 1ps
// Commit: a character's segments are registered into the output queue at accept;
//   a tab's segments after 16 remainder steps of the column in ST_DIV, then the ST_DONE commit.
// Throughput: one non-tab character per cycle while the queue has room; a tab holds the input
//   until its ST_DONE commit, set by the bit-serial column-modulo-tab-stop unit.
// Input stalls while the four-word output queue has fewer than two free words.
// Reset: asynchronous, active low; clears line state and queue, tab_stop to 8.
// ----------------------------------------------------------------------------
// wrap_run_segmenter_core: splits one text line into display runs
// APB register for tab_stop, controller and datapath.
// ----------------------------------------------------------------------------
module wrap_run_segmenter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// codepoint[20:0], byte_count[23:21], glyph_width[25:24], zero[31:26]
	input  logic [wrsg_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                  s_tlast,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// seg_offset[15:0], seg_len[31:16], seg_cols[47:32], seg_cnt[63:48],
	// line_flags[66:64], total_width[82:67], zero[87:83]
	output logic [wrsg_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// seg_class[1:0]
	output logic [1:0]                            m_tuser,
	output logic                                  m_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [wrsg_pkg::APB_AW-1:0]           paddr,
	input  logic [wrsg_pkg::APB_DW-1:0]           pwdata,
	output logic [wrsg_pkg::APB_DW-1:0]           prdata,
	output logic                                  pready
);
	import wrsg_pkg::*;

	logic [TS_W-1:0] tab_stop_q;
	logic            reg_sel;
	cmd_t            cmd;
	status_t         status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_TAB_STOP);
	assign prdata  = reg_sel ? {{(APB_DW-TS_W){1'b0}}, tab_stop_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_stop_q <= TAB_STOP_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tab_stop_q <= pwdata[TS_W-1:0];
		end
	end

	wrsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wrsg_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.tab_stop (tab_stop_q),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: design/wrsg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsg_ctrl: controller of the wrap run segmenter
// Accepts input words, sequences the tab remainder steps and commits items.
// ----------------------------------------------------------------------------
module wrsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  wrsg_pkg::status_t status,
	output wrsg_pkg::cmd_t    cmd
);
	import wrsg_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.live_tab) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready        = (state_q == ST_IDLE) && status.room;
		accept          = s_tvalid && s_tready;
		cmd.commit_live = accept && !status.live_tab;
		cmd.start_div   = accept && status.live_tab;
		cmd.div_step    = (state_q == ST_DIV);
		cmd.commit_held = (state_q == ST_DONE);
	end

endmodule

FILE: design/wrsg_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsg_dpath: datapath of the wrap run segmenter
// Line state, bit-serial column remainder for tabs, segment build and a
// four-word result queue.
// ----------------------------------------------------------------------------
module wrsg_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [wrsg_pkg::TS_W-1:0]             tab_stop,
	input  logic [wrsg_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                  s_tlast,
	input  wrsg_pkg::cmd_t                        cmd,
	output wrsg_pkg::status_t                     status,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [wrsg_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic [1:0]                            m_tuser,
	output logic                                  m_tlast
);
	import wrsg_pkg::*;

	// line state
	logic [SEG_W-1:0]  byte_pos_q, column_q, run_start_q, run_bytes_q;
	logic [SEG_W-1:0]  run_width_q, run_chars_q, total_q;
	kind_t             run_kind_q;
	logic              run_open_q;
	logic [FLAG_W-1:0] flag_q;

	// held tab item and remainder unit
	logic [BC_W-1:0]   hold_bc_q;
	logic              hold_end_q;
	logic [TS_W-1:0]   rem_q;
	logic [3:0]        div_cnt_q;
	logic [TS_W-1:0]   ts_eff;
	logic [TS_W:0]     rem_shift;
	logic [TS_W:0]     rem_next;
	logic [TS_W-1:0]   tab_w;

	// result queue
	seg_t              fifo_q [4];
	logic [1:0]        wr_ptr_q, rd_ptr_q;
	logic [2:0]        count_q;
	logic              pop;
	logic [2:0]        push_n;
	seg_t              head;

	// commit
	logic              commit, sel_held;
	logic [CP_W-1:0]   cp;
	logic [BC_W-1:0]   bc, bc_e;
	logic [GW_W-1:0]   gw;
	logic              end_i;
	kind_t             kind;
	logic [SEG_W-1:0]  w;
	logic [FLAG_W-1:0] flags_n;
	logic              close, second, fresh;
	logic [SEG_W-1:0]  t1, t2;
	logic [SEG_W-1:0]  nb_bytes, nb_width, nb_chars, nb_start;
	seg_t              r1, r2;

	assign ts_eff    = (tab_stop == '0) ? TS_W'(1) : tab_stop;
	assign rem_shift = {rem_q, column_q[div_cnt_q]};
	assign rem_next  = (rem_shift >= {1'b0, ts_eff}) ? rem_shift - {1'b0, ts_eff} : rem_shift;
	assign tab_w     = ts_eff - rem_q;

	assign status.live_tab = (s_tdata[CP_W-1:0] == CP_TAB);
	assign status.div_last = (div_cnt_q == '0);
	assign status.room     = (count_q <= 3'd2);

	assign commit   = cmd.commit_live || cmd.commit_held;
	assign sel_held = cmd.commit_held;

	always_comb begin
		cp    = sel_held ? CP_TAB : s_tdata[CP_W-1:0];
		bc    = sel_held ? hold_bc_q : s_tdata[CP_W+BC_W-1:CP_W];
		gw    = s_tdata[CP_W+BC_W+GW_W-1:CP_W+BC_W];
		end_i = sel_held ? hold_end_q : s_tlast;
		bc_e  = (bc == '0) ? BC_W'(1) : bc;
		flags_n = flag_q;
		if (cp == CP_TAB) begin
			kind    = KIND_TAB;
			w       = SEG_W'(tab_w);
			flags_n = flag_q | FLAG_TAB;
		end else if (cp == CP_SPACE) begin
			kind = KIND_SPACE;
			w    = SEG_W'(1);
		end else if (cp < CP_SPACE || cp == CP_DEL) begin
			kind    = KIND_CTRL;
			w       = SEG_W'(2);
			flags_n = flag_q | FLAG_CTRL;
		end else begin
			kind = KIND_TEXT;
			w    = (gw[1]) ? SEG_W'(2) : SEG_W'(1);
			if (gw[1]) flags_n = flag_q | FLAG_WIDE;
		end

		close  = run_open_q && (kind == KIND_TAB || kind != run_kind_q);
		second = (kind == KIND_TAB) || end_i;
		fresh  = close || !run_open_q;
		t1     = close ? sat_add(total_q, run_width_q, WIDTH_MAX) : total_q;

		nb_start = fresh ? byte_pos_q : run_start_q;
		nb_bytes = sat_add(fresh ? '0 : run_bytes_q, SEG_W'(bc_e), MAX_LINE_BYTES);
		nb_width = sat_add(fresh ? '0 : run_width_q, w, WIDTH_MAX);
		nb_chars = sat_add(fresh ? '0 : run_chars_q, SEG_W'(1), WIDTH_MAX);

		r1.offset    = run_start_q;
		r1.bytes     = run_bytes_q;
		r1.width     = run_width_q;
		r1.chars     = run_chars_q;
		r1.kind      = run_kind_q;
		r1.flags     = flags_n;
		r1.total     = t1;
		r1.final_seg = 1'b0;

		if (kind == KIND_TAB) begin
			t2        = sat_add(t1, w, WIDTH_MAX);
			r2.offset = byte_pos_q;
			r2.bytes  = SEG_W'(bc_e);
			r2.width  = w;
			r2.chars  = SEG_W'(1);
			r2.kind   = KIND_TAB;
		end else begin
			t2        = sat_add(t1, nb_width, WIDTH_MAX);
			r2.offset = nb_start;
			r2.bytes  = nb_bytes;
			r2.width  = nb_width;
			r2.chars  = nb_chars;
			r2.kind   = kind;
		end
		r2.flags     = flags_n;
		r2.total     = t2;
		r2.final_seg = end_i;

		push_n = 3'd0;
		if (commit) push_n = {2'b00, close} + {2'b00, second};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			column_q    <= '0;
			run_start_q <= '0;
			run_bytes_q <= '0;
			run_width_q <= '0;
			run_chars_q <= '0;
			run_kind_q  <= KIND_TEXT;
			run_open_q  <= 1'b0;
			flag_q      <= '0;
			total_q     <= '0;
		end else if (commit) begin
			if (end_i) begin
				byte_pos_q  <= '0;
				column_q    <= '0;
				run_start_q <= '0;
				run_bytes_q <= '0;
				run_width_q <= '0;
				run_chars_q <= '0;
				run_kind_q  <= KIND_TEXT;
				run_open_q  <= 1'b0;
				flag_q      <= '0;
				total_q     <= '0;
			end else begin
				byte_pos_q <= sat_add(byte_pos_q, SEG_W'(bc_e), MAX_LINE_BYTES);
				column_q   <= sat_add(column_q, w, WIDTH_MAX);
				flag_q     <= flags_n;
				total_q    <= (kind == KIND_TAB) ? t2 : t1;
				if (kind == KIND_TAB) begin
					run_open_q <= 1'b0;
				end else begin
					run_open_q  <= 1'b1;
					run_start_q <= nb_start;
					run_bytes_q <= nb_bytes;
					run_width_q <= nb_width;
					run_chars_q <= nb_chars;
					run_kind_q  <= kind;
				end
			end
		end
	end

	// hold the tab item and step the column remainder one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			hold_bc_q  <= s_tdata[CP_W+BC_W-1:CP_W];
			hold_end_q <= s_tlast;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next[TS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.start_div) begin
			div_cnt_q <= DIV_FIRST_BIT;
		end else if (cmd.div_step && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 4'd1;
		end
	end

	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {5'b0, head.total, head.flags, head.chars, head.width,
		head.bytes, head.offset};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.final_seg;

	always_ff @(posedge clk) begin
		if (commit) begin
			if (close) begin
				fifo_q[wr_ptr_q] <= r1;
				if (second) fifo_q[wr_ptr_q + 2'd1] <= r2;
			end else if (second) begin
				fifo_q[wr_ptr_q] <= r2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[1:0];
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + push_n - {2'b00, pop};
		end
	end

endmodule

FILE: test/wrsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsg_checker: segment predictor and scoreboard for the wrap run segmenter
// Watches the character, segment and register channels. Every accepted
// character updates a private copy of the line state and queues the segments
// it closes. Every accepted segment word is compared field by field with the
// oldest queued one. Register writes update the local tab stop, and register
// reads are compared with it.
// ----------------------------------------------------------------------------
module wrsg_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [wrsg_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                  s_tlast,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [wrsg_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic [1:0]                            m_tuser,
	input  logic                                  m_tlast,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [wrsg_pkg::APB_AW-1:0]           paddr,
	input  logic [wrsg_pkg::APB_DW-1:0]           pwdata,
	input  logic [wrsg_pkg::APB_DW-1:0]           prdata,
	input  logic                                  pready,
	output int                                    fail_count,
	output int                                    pending
);
	import wrsg_pkg::*;

	seg_t               expected_segs[$];
	logic [TS_W-1:0]    tab_cols;
	logic [SEG_W-1:0]   line_pos;
	logic [SEG_W-1:0]   col;
	logic [SEG_W-1:0]   run_off;
	logic [SEG_W-1:0]   run_len;
	logic [SEG_W-1:0]   run_cols;
	logic [SEG_W-1:0]   run_cnt;
	logic [SEG_W-1:0]   emitted_cols;
	kind_t              run_class;
	logic               run_live;
	logic [FLAG_W-1:0]  seen_flags;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [SEG_W-1:0] clamp_add(input logic [SEG_W-1:0] a,
			input logic [SEG_W-1:0] b);
		logic [SEG_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SEG_W] ? {SEG_W{1'b1}} : s[SEG_W-1:0];
	endfunction

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic clear_line();
		line_pos = '0;
		col = '0;
		run_off = '0;
		run_len = '0;
		run_cols = '0;
		run_cnt = '0;
		run_class = KIND_TEXT;
		run_live = 1'b0;
		seen_flags = '0;
		emitted_cols = '0;
	endtask

	task automatic close_seg(input logic [SEG_W-1:0] off, input logic [SEG_W-1:0] len,
			input logic [SEG_W-1:0] cols, input logic [SEG_W-1:0] cnt, input kind_t k,
			input logic last);
		seg_t s;
		emitted_cols = clamp_add(emitted_cols, cols);
		s.offset = off;
		s.bytes = len;
		s.width = cols;
		s.chars = cnt;
		s.kind = k;
		s.flags = seen_flags;
		s.total = emitted_cols;
		s.final_seg = last;
		expected_segs.push_back(s);
	endtask

	task automatic segment_char(input logic [IN_TDATA_W-1:0] word, input logic last);
		logic [CP_W-1:0]  cp;
		logic [BC_W-1:0]  bc;
		logic [GW_W-1:0]  gw;
		logic [SEG_W-1:0] w;
		kind_t            k;
		int               ts;
		cp = word[CP_W-1:0];
		bc = word[CP_W+BC_W-1:CP_W];
		gw = word[CP_W+BC_W+GW_W-1:CP_W+BC_W];
		if (bc == '0)
			bc = BC_W'(1);
		ts = (tab_cols == '0) ? 1 : int'(tab_cols);
		if (cp == CP_TAB) begin
			k = KIND_TAB;
			w = SEG_W'(ts - (int'(col) % ts));
			seen_flags |= FLAG_TAB;
		end else if (cp == CP_SPACE) begin
			k = KIND_SPACE;
			w = SEG_W'(1);
		end else if (cp < CP_SPACE || cp == CP_DEL) begin
			k = KIND_CTRL;
			w = SEG_W'(2);
			seen_flags |= FLAG_CTRL;
		end else begin
			k = KIND_TEXT;
			w = (gw == '0) ? SEG_W'(1) : ((gw >= 2) ? SEG_W'(2) : SEG_W'(gw));
			if (w == 2)
				seen_flags |= FLAG_WIDE;
		end

		if (run_live && (k == KIND_TAB || k != run_class)) begin
			close_seg(run_off, run_len, run_cols, run_cnt, run_class, 1'b0);
			run_live = 1'b0;
		end

		if (k == KIND_TAB) begin
			close_seg(line_pos, SEG_W'(bc), w, SEG_W'(1), KIND_TAB, last);
		end else begin
			if (!run_live) begin
				run_off = line_pos;
				run_class = k;
				run_len = '0;
				run_cols = '0;
				run_cnt = '0;
				run_live = 1'b1;
			end
			run_len = clamp_add(run_len, SEG_W'(bc));
			run_cols = clamp_add(run_cols, w);
			run_cnt = clamp_add(run_cnt, SEG_W'(1));
		end

		col = clamp_add(col, w);
		line_pos = clamp_add(line_pos, SEG_W'(bc));

		if (last) begin
			if (run_live)
				close_seg(run_off, run_len, run_cols, run_cnt, run_class, 1'b1);
			clear_line();
		end
	endtask

	task automatic check_seg();
		seg_t got;
		seg_t want;
		got.offset = m_tdata[15:0];
		got.bytes = m_tdata[31:16];
		got.width = m_tdata[47:32];
		got.chars = m_tdata[63:48];
		got.flags = m_tdata[66:64];
		got.total = m_tdata[82:67];
		got.kind = kind_t'(m_tuser);
		got.final_seg = m_tlast;
		if (expected_segs.size() == 0) begin
			note_fail($sformatf("unexpected segment word: off %0d bytes %0d width %0d",
				got.offset, got.bytes, got.width));
		end else begin
			want = expected_segs.pop_front();
			if (got.offset !== want.offset || got.bytes !== want.bytes ||
					got.width !== want.width || got.chars !== want.chars ||
					got.kind !== want.kind || got.flags !== want.flags ||
					got.total !== want.total || got.final_seg !== want.final_seg ||
					m_tdata[87:83] !== '0)
				note_fail($sformatf({"segment mismatch: expected off %0d bytes %0d ",
					"width %0d chars %0d kind %0d flags %b total %0d last %b; got off %0d ",
					"bytes %0d width %0d chars %0d kind %0d flags %b total %0d last %b pad %h"},
					want.offset, want.bytes, want.width, want.chars, want.kind, want.flags,
					want.total, want.final_seg, got.offset, got.bytes, got.width, got.chars,
					got.kind, got.flags, got.total, got.final_seg, m_tdata[87:83]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			tab_cols = TAB_STOP_RST;
			expected_segs.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_seg();
			if (psel && penable && pready && paddr == {REG_TAB_STOP, 2'b00}) begin
				if (pwrite)
					tab_cols = pwdata[TS_W-1:0];
				else if (prdata !== APB_DW'(tab_cols))
					note_fail($sformatf("tab_stop read: expected %0d got %0d",
						tab_cols, prdata));
			end
			if (s_tvalid && s_tready)
				segment_char(s_tdata, s_tlast);
		end
		pending = expected_segs.size();
	end

endmodule

FILE: test/wrap_run_segmenter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrap_run_segmenter_core_tb: character stimulus for the wrap run segmenter
// Drives a short directed line set, then random lines built from runs of
// text, space, control and tab characters under several tab stops, with
// random idling on both sides and one long receiver stall. A checker beside
// the block predicts and compares the segment words.
// ----------------------------------------------------------------------------
module wrap_run_segmenter_core_tb;
	import wrsg_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    s_tlast;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic [1:0]              m_tuser;
	logic                    m_tlast;
	logic                    m_tvalid;
	logic                    m_tready;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_AW-1:0]       paddr;
	logic [APB_DW-1:0]       pwdata;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;

	int  fail_count;
	int  pending;
	bit  calm;
	int  hold_cycles;
	int  sent_words;

	wrap_run_segmenter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	wrsg_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL wrap_run_segmenter_core");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 24);
			end
		end
	end

	task automatic send_char(input logic [CP_W-1:0] cp, input logic [BC_W-1:0] bc,
			input logic [GW_W-1:0] gw, input logic last);
		if (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tdata <= IN_TDATA_W'({gw, bc, cp});
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent_words++;
	endtask

	task automatic apb_access(input bit wr, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_TAB_STOP, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [CP_W-1:0] pick_cp(input kind_t k);
		logic [CP_W-1:0] cp;
		case (k)
			KIND_SPACE: cp = CP_SPACE;
			KIND_TAB:   cp = CP_TAB;
			KIND_CTRL: begin
				cp = ($urandom_range(3) == 0) ? CP_DEL : CP_W'($urandom_range(0, 31));
				if (cp == CP_TAB)
					cp = '0;
			end
			default: begin
				if ($urandom_range(1) == 0)
					cp = CP_W'($urandom_range(33, 126));
				else
					cp = CP_W'($urandom_range(33, 21'h1FFFFF));
				if (cp == CP_DEL)
					cp = 21'h41;
			end
		endcase
		return cp;
	endfunction

	function automatic kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return KIND_TEXT;
		else if (r < 72)
			return KIND_SPACE;
		else if (r < 88)
			return KIND_CTRL;
		return KIND_TAB;
	endfunction

	task automatic send_line();
		int    len;
		int    run;
		kind_t k;
		len = ($urandom_range(9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
		while (len > 0) begin
			k = pick_kind();
			run = (k == KIND_TAB) ? $urandom_range(1, 2) : $urandom_range(1, 6);
			while (run > 0 && len > 0) begin
				send_char(pick_cp(k),
					($urandom_range(4) == 0) ? BC_W'($urandom_range(0, 7))
						: BC_W'($urandom_range(1, 4)),
					GW_W'($urandom_range(0, 3)), len == 1);
				run--;
				len--;
			end
		end
	endtask

	initial begin
		int stop_val;
		int start_count;
		bit pressed;
		arst_n <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		s_tvalid <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm = 1'b0;
		hold_cycles = 0;
		sent_words = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines under the reset tab stop
		apb_access(1'b0, '0);
		send_char(21'h41, 3'd1, 2'd1, 1'b0);
		send_char(21'h42, 3'd1, 2'd0, 1'b0);
		send_char(21'h4E2D, 3'd3, 2'd2, 1'b0);
		send_char(21'h1FFFFF, 3'd4, 2'd3, 1'b0);
		send_char(CP_SPACE, 3'd1, 2'd0, 1'b0);
		send_char(CP_SPACE, 3'd0, 2'd3, 1'b0);
		send_char(CP_TAB, 3'd1, 2'd0, 1'b0);
		send_char(21'd0, 3'd1, 2'd1, 1'b0);
		send_char(CP_DEL, 3'd0, 2'd0, 1'b0);
		send_char(21'd31, 3'd7, 2'd2, 1'b0);
		send_char(CP_TAB, 3'd5, 2'd0, 1'b0);
		send_char(CP_TAB, 3'd1, 2'd3, 1'b0);
		send_char(21'h10FFFF, 3'd7, 2'd1, 1'b0);
		send_char(21'h80, 3'd2, 2'd2, 1'b0);
		send_char(CP_SPACE, 3'd1, 2'd1, 1'b1);
		send_char(CP_TAB, 3'd1, 2'd0, 1'b1);
		send_char(21'h7E, 3'd1, 2'd1, 1'b1);
		send_char(CP_SPACE, 3'd1, 2'd0, 1'b0);
		send_char(21'd10, 3'd1, 2'd0, 1'b1);
		send_char(21'h21, 3'd6, 2'd0, 1'b0);
		send_char(CP_TAB, 3'd1, 2'd0, 1'b1);

		// random lines under a sequence of tab stops
		pressed = 1'b0;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: stop_val = 1;
				1: stop_val = 64;
				2: stop_val = 0;
				3: stop_val = 127;
				4: stop_val = 3;
				default: stop_val = $urandom_range(1, 64);
			endcase
			drain();
			apb_access(1'b1, APB_DW'(stop_val));
			apb_access(1'b0, '0);
			calm = (p == 2);
			start_count = sent_words;
			while (sent_words - start_count < 150) begin
				if (p == 3 && !pressed && sent_words - start_count > 20) begin
					hold_cycles = 400;
					pressed = 1'b1;
				end
				send_line();
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("PASS wrap_run_segmenter_core");
		else
			$display("FAIL wrap_run_segmenter_core");
		$finish;
	end

endmodule
